### rtl/rs_tbl_pkg.sv
// shared types and constants for the reservation station table
// no dependencies; imported by rs_tbl_cell, reservation_station_table and tb
package rs_tbl_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int TAG_WIDTH   = 8;
  localparam int IDX_W       = $clog2(ENTRY_COUNT);
  localparam int ACT_W       = 5;
  localparam int NUM_W       = 32;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_WAKEUP   = 2'd2,
    KIND_SCHEDULE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_NO_FREE   = 2'd1,
    ERR_NOT_FOUND = 2'd2,
    ERR_DUPLICATE = 2'd3
  } err_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [NUM_W-1:0]     inst_number;
    logic                 src1_present;
    logic [TAG_WIDTH-1:0] opnd1_tag;
    logic                 opnd1_rdy;
    logic                 src2_present;
    logic [TAG_WIDTH-1:0] opnd2_tag;
    logic                 opnd2_rdy;
    logic [TAG_WIDTH-1:0] wake_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       error_code;
    logic [IDX_W-1:0] slot_used;
    logic             has_space;
  } out_item_t;

  // state handed from one cell to the next
  typedef struct packed {
    logic       placed;    // an earlier cell took the insert
    logic [1:0] match_cnt; // remove matches so far, saturates at two
    logic       space;     // an earlier active cell is free after the op
  } chain_t;

endpackage

### rtl/rs_tbl_cell.sv
// one entry of the reservation station table
// depends on rs_tbl_pkg; a row of these is chained in reservation_station_table
module rs_tbl_cell
  import rs_tbl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  in_item_t op,
  input  logic     act,
  input  chain_t   chain_in,
  output chain_t   chain_out,
  output logic     claim
);

  logic                 valid_r, valid_nxt;
  logic                 sched_r, sched_nxt;
  logic [NUM_W-1:0]     number_r;
  logic                 s1_present_r, s2_present_r;
  logic [TAG_WIDTH-1:0] s1_tag_r, s2_tag_r;
  logic                 s1_ready_r, s2_ready_r;

  logic match, rm, mark, wake1, wake2;

  always_comb begin
    match = valid_r && act && (number_r == op.inst_number);
    claim = go && (op.kind == KIND_INSERT) && act && !valid_r && !chain_in.placed;
    rm    = go && (op.kind == KIND_REMOVE) && match;
    mark  = go && (op.kind == KIND_SCHEDULE) && match;
    wake1 = go && (op.kind == KIND_WAKEUP) && valid_r && act && s1_present_r &&
            (s1_tag_r == op.wake_tag);
    wake2 = go && (op.kind == KIND_WAKEUP) && valid_r && act && s2_present_r &&
            (s2_tag_r == op.wake_tag);

    valid_nxt = valid_r;
    sched_nxt = sched_r;
    if (claim) begin
      valid_nxt = 1'b1;
      sched_nxt = 1'b0;
    end else if (rm) begin
      valid_nxt = 1'b0;
      sched_nxt = 1'b0;
    end else if (mark) begin
      sched_nxt = 1'b1;
    end

    chain_out.placed    = chain_in.placed | claim;
    chain_out.match_cnt = chain_in.match_cnt;
    if (rm && chain_in.match_cnt != 2'd2) begin
      chain_out.match_cnt = chain_in.match_cnt + 2'd1;
    end
    chain_out.space = chain_in.space | (act && !valid_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sched_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sched_r <= sched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      number_r     <= op.inst_number;
      s1_present_r <= op.src1_present;
      s1_tag_r     <= op.opnd1_tag;
      s1_ready_r   <= op.opnd1_rdy;
      s2_present_r <= op.src2_present;
      s2_tag_r     <= op.opnd2_tag;
      s2_ready_r   <= op.opnd2_rdy;
    end else if (rm) begin
      s1_ready_r <= 1'b0;
      s2_ready_r <= 1'b0;
    end else begin
      if (wake1) s1_ready_r <= 1'b1;
      if (wake2) s2_ready_r <= 1'b1;
    end
  end

endmodule

### rtl/reservation_station_table.sv
// reservation station table: a row of ENTRY_COUNT rs_tbl_cell entries
// depends on rs_tbl_pkg and rs_tbl_cell
//
// usage:
//   an item (insert, remove, wakeup or schedule) is taken at a rising edge
//   with start high and busy low. busy then goes high while the op is
//   applied to every entry at once.
//   each item gives exactly one result on out_item, with out_valid high for
//   one cycle; the result passes through pend_r (busy), then out_r and out_valid_r. the receiver cannot stall.
//   a new item is not taken while busy is high; the table updates in the busy
//   cycle through the cell row, and out_r then registers the result.
//   a new item may be started in the cycle in which the previous result shows.
//   the first-free search and the remove match count ripple along the row.
//   the user must write register 0 at byte address 0 (active_entries, 5 bits)
//   via apb only while idle; the block does not enforce it. values above the
//   depth act as it; reset empties the table and sets active_entries to it.
module reservation_station_table
  import rs_tbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ACT_W-1:0] active_r;
  logic             pend_r;
  in_item_t         op_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [ACT_W:0]         live;
  logic [ENTRY_COUNT-1:0] act;
  logic [ENTRY_COUNT-1:0] claim;
  chain_t                 chain [ENTRY_COUNT+1];
  logic [IDX_W-1:0]       slot;
  out_item_t              out_nxt;
  logic                   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {{(32-ACT_W){1'b0}}, active_r} : 32'd0;

  assign busy      = pend_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    if ({1'b0, active_r} > (ACT_W+1)'(ENTRY_COUNT)) begin
      live = (ACT_W+1)'(ENTRY_COUNT);
    end else begin
      live = {1'b0, active_r};
    end
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      act[i] = ((ACT_W+1)'(i) < live);
    end
  end

  assign chain[0] = '{placed: 1'b0, match_cnt: 2'd0, space: 1'b0};

  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
    rs_tbl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .go        (pend_r),
      .op        (op_r),
      .act       (act[g]),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .claim     (claim[g])
    );
  end

  always_comb begin
    slot = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (claim[i]) slot = slot | IDX_W'(i);
    end
  end

  always_comb begin
    out_nxt.error_code = ERR_OK;
    out_nxt.slot_used  = '0;
    out_nxt.has_space  = chain[ENTRY_COUNT].space;
    case (op_r.kind)
      KIND_INSERT: begin
        if (chain[ENTRY_COUNT].placed) out_nxt.slot_used = slot;
        else                           out_nxt.error_code = ERR_NO_FREE;
      end
      KIND_REMOVE: begin
        if (chain[ENTRY_COUNT].match_cnt == 2'd0) out_nxt.error_code = ERR_NOT_FOUND;
        else if (chain[ENTRY_COUNT].match_cnt == 2'd2) out_nxt.error_code = ERR_DUPLICATE;
      end
      default: begin
        out_nxt.error_code = ERR_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACT_W'(ENTRY_COUNT);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && reg_sel) begin
        active_r <= pwdata[ACT_W-1:0];
      end
      pend_r      <= start && !pend_r;
      out_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !pend_r) op_r <= in_item;
    if (pend_r) out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_one_claim: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(claim))
    else $error("more than one entry took an insert");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 out_valid)
    else $error("item did not produce a result two cycles later");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while an item is in flight");
  a_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.slot_used != '0) |-> (out_item.error_code == ERR_OK))
    else $error("nonzero slot reported with an error");
`endif

endmodule

### sim/tb.sv
// testbench for reservation_station_table: directed and random operations checked
// against a behavioral copy of the entry table kept in this file
// depends on rs_tbl_pkg and the reservation_station_table rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rs_tbl_pkg::*;

  localparam logic [2:0] REG_ACTIVE_ENTRIES = 3'd0;
  localparam int MAX_REPORTS = 10;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_item_t        in_item;
  logic            out_valid;
  out_item_t       out_item;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  // behavioral copy of the table
  logic [ACT_W-1:0]     act_cfg;
  bit                   tbl_valid [ENTRY_COUNT];
  bit                   tbl_sched [ENTRY_COUNT];
  logic [NUM_W-1:0]     tbl_num   [ENTRY_COUNT];
  bit                   tbl_p1    [ENTRY_COUNT];
  logic [TAG_WIDTH-1:0] tbl_t1    [ENTRY_COUNT];
  bit                   tbl_r1    [ENTRY_COUNT];
  bit                   tbl_p2    [ENTRY_COUNT];
  logic [TAG_WIDTH-1:0] tbl_t2    [ENTRY_COUNT];
  bit                   tbl_r2    [ENTRY_COUNT];

  out_item_t            pending_results [$];
  int                   fail_count = 0;
  logic [NUM_W-1:0]     num_pool [8];
  logic [TAG_WIDTH-1:0] tag_pool [6];

  reservation_station_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic out_item_t apply_to_table(in_item_t it);
    out_item_t res;
    int        live;
    int        hits;
    bit        placed;
    res = '0;
    live = (act_cfg > ENTRY_COUNT) ? ENTRY_COUNT : int'(act_cfg);
    hits = 0;
    placed = 1'b0;
    case (it.kind)
      KIND_INSERT: begin
        for (int i = 0; i < live; i++) begin
          if (!placed && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_sched[i] = 1'b0;
            tbl_num[i]   = it.inst_number;
            tbl_p1[i]    = it.src1_present;
            tbl_t1[i]    = it.opnd1_tag;
            tbl_r1[i]    = it.opnd1_rdy;
            tbl_p2[i]    = it.src2_present;
            tbl_t2[i]    = it.opnd2_tag;
            tbl_r2[i]    = it.opnd2_rdy;
            res.slot_used = IDX_W'(i);
            placed = 1'b1;
          end
        end
        if (!placed) res.error_code = ERR_NO_FREE;
      end
      KIND_REMOVE: begin
        for (int i = 0; i < live; i++) begin
          if (tbl_valid[i] && tbl_num[i] == it.inst_number) begin
            tbl_valid[i] = 1'b0;
            tbl_sched[i] = 1'b0;
            tbl_r1[i]    = 1'b0;
            tbl_r2[i]    = 1'b0;
            hits++;
          end
        end
        if (hits == 0) res.error_code = ERR_NOT_FOUND;
        else if (hits > 1) res.error_code = ERR_DUPLICATE;
      end
      KIND_WAKEUP: begin
        for (int i = 0; i < live; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_p1[i] && tbl_t1[i] == it.wake_tag) tbl_r1[i] = 1'b1;
            if (tbl_p2[i] && tbl_t2[i] == it.wake_tag) tbl_r2[i] = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < live; i++)
          if (tbl_valid[i] && tbl_num[i] == it.inst_number) tbl_sched[i] = 1'b1;
      end
    endcase
    res.has_space = 1'b0;
    for (int i = 0; i < live; i++)
      if (!tbl_valid[i]) res.has_space = 1'b1;
    return res;
  endfunction

  function automatic in_item_t mk(kind_t k, logic [NUM_W-1:0] num,
                                  logic [TAG_WIDTH-1:0] t1, logic [TAG_WIDTH-1:0] t2,
                                  logic [3:0] flags, logic [TAG_WIDTH-1:0] wt);
    in_item_t it;
    it.kind         = k;
    it.inst_number  = num;
    it.src1_present = flags[3];
    it.opnd1_tag    = t1;
    it.opnd1_rdy    = flags[2];
    it.src2_present = flags[1];
    it.opnd2_tag    = t2;
    it.opnd2_rdy    = flags[0];
    it.wake_tag     = wt;
    return it;
  endfunction

  // mostly well-formed traffic: numbers and tags that hit live entries
  function automatic in_item_t make_item(int ins_pct);
    in_item_t             it;
    int                   live;
    int                   sel;
    logic [NUM_W-1:0]     held [$];
    logic [TAG_WIDTH-1:0] waiting [$];
    live = (act_cfg > ENTRY_COUNT) ? ENTRY_COUNT : int'(act_cfg);
    for (int i = 0; i < live; i++) begin
      if (tbl_valid[i]) begin
        held.push_back(tbl_num[i]);
        if (tbl_p1[i]) waiting.push_back(tbl_t1[i]);
        if (tbl_p2[i]) waiting.push_back(tbl_t2[i]);
      end
    end
    it.inst_number  = $urandom();
    it.src1_present = 1'($urandom_range(0, 1));
    it.opnd1_tag    = TAG_WIDTH'($urandom_range(0, 255));
    it.opnd1_rdy    = 1'($urandom_range(0, 1));
    it.src2_present = 1'($urandom_range(0, 1));
    it.opnd2_tag    = TAG_WIDTH'($urandom_range(0, 255));
    it.opnd2_rdy    = 1'($urandom_range(0, 1));
    it.wake_tag     = TAG_WIDTH'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < ins_pct) begin
      it.kind = KIND_INSERT;
      if ($urandom_range(0, 3) != 0) it.inst_number = num_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 4) < 3) it.opnd1_tag = tag_pool[$urandom_range(0, 5)];
      if ($urandom_range(0, 4) < 3) it.opnd2_tag = tag_pool[$urandom_range(0, 5)];
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 4) it.kind = KIND_REMOVE;
      else if (sel < 7) it.kind = KIND_WAKEUP;
      else it.kind = KIND_SCHEDULE;
      if (held.size() != 0 && $urandom_range(0, 9) < 7)
        it.inst_number = held[$urandom_range(0, held.size() - 1)];
      else if ($urandom_range(0, 1) == 0)
        it.inst_number = num_pool[$urandom_range(0, 7)];
      if (waiting.size() != 0 && $urandom_range(0, 9) < 7)
        it.wake_tag = waiting[$urandom_range(0, waiting.size() - 1)];
      else if ($urandom_range(0, 1) == 0)
        it.wake_tag = tag_pool[$urandom_range(0, 5)];
    end
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_op(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_to_table(it));
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [ACT_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_ACTIVE_ENTRIES;
    pwdata  <= {(32-ACT_W)'($urandom_range(0, 32'h07FF_FFFF)), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    act_cfg = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_basic_ops();
    send_op(mk(KIND_INSERT, 32'h0000_0000, 8'h00, 8'hFF, 4'b1010, 8'h00));
    send_op(mk(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'h00, 4'b0101, 8'hFF));
    send_op(mk(KIND_INSERT, 32'h0000_0000, 8'hFF, 8'h00, 4'b1110, 8'h00));
    send_op(mk(KIND_WAKEUP, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 4'b1111, 8'h00));
    send_op(mk(KIND_WAKEUP, 32'h0000_0000, 8'h00, 8'h00, 4'b0000, 8'hFF));
    send_op(mk(KIND_SCHEDULE, 32'hFFFF_FFFF, 8'h00, 8'h00, 4'b0000, 8'h00));
    send_op(mk(KIND_SCHEDULE, 32'h0000_0005, 8'h00, 8'h00, 4'b0000, 8'h00));
    // two entries share number zero
    send_op(mk(KIND_REMOVE, 32'h0000_0000, 8'h00, 8'h00, 4'b0000, 8'h00));
    send_op(mk(KIND_REMOVE, 32'h0000_0000, 8'hFF, 8'hFF, 4'b1111, 8'hFF));
    send_op(mk(KIND_REMOVE, 32'hFFFF_FFFF, 8'h00, 8'h00, 4'b0000, 8'h00));
  endtask

  task automatic test_window_limits();
    cfg_write(5'd0);
    send_op(mk(KIND_INSERT, 32'h0000_0055, 8'h12, 8'h34, 4'b1111, 8'h00));
    send_op(mk(KIND_REMOVE, 32'h0000_0055, 8'h00, 8'h00, 4'b0000, 8'h00));
    send_op(mk(KIND_WAKEUP, 32'h0000_0000, 8'h00, 8'h00, 4'b0000, 8'h12));
    send_op(mk(KIND_SCHEDULE, 32'h0000_0055, 8'h00, 8'h00, 4'b0000, 8'h00));
    // above the depth behaves as the full depth
    cfg_write(5'd31);
    send_op(mk(KIND_INSERT, 32'h0000_0055, 8'h12, 8'h34, 4'b1010, 8'h00));
    cfg_write(5'd1);
    send_op(mk(KIND_INSERT, 32'h0000_0066, 8'h12, 8'h34, 4'b1010, 8'h00));
    send_op(mk(KIND_REMOVE, 32'h0000_0055, 8'h00, 8'h00, 4'b0000, 8'h00));
  endtask

  task automatic test_shrunk_window();
    cfg_write(5'd16);
    send_op(mk(KIND_INSERT, 32'h0000_000A, 8'h01, 8'h02, 4'b1010, 8'h00));
    send_op(mk(KIND_INSERT, 32'h0000_000B, 8'h03, 8'h04, 4'b1010, 8'h00));
    send_op(mk(KIND_INSERT, 32'h0000_000C, 8'h05, 8'h06, 4'b1010, 8'h00));
    // entry two is outside the window now and must be left alone
    cfg_write(5'd2);
    send_op(mk(KIND_REMOVE, 32'h0000_000C, 8'h00, 8'h00, 4'b0000, 8'h00));
    send_op(mk(KIND_WAKEUP, 32'h0000_000C, 8'h00, 8'h00, 4'b0000, 8'h05));
    send_op(mk(KIND_INSERT, 32'h0000_000D, 8'h07, 8'h08, 4'b1111, 8'h00));
    cfg_write(5'd16);
    send_op(mk(KIND_REMOVE, 32'h0000_000C, 8'h00, 8'h00, 4'b0000, 8'h00));
    send_op(mk(KIND_REMOVE, 32'h0000_000A, 8'h00, 8'h00, 4'b0000, 8'h00));
    send_op(mk(KIND_REMOVE, 32'h0000_000B, 8'h00, 8'h00, 4'b0000, 8'h00));
  endtask

  task automatic run_phase(input logic [ACT_W-1:0] active, input int count,
                           input int ins_pct, input bit idle_on, input int drain_every);
    cfg_write(active);
    for (int n = 0; n < count; n++) begin
      send_op(make_item(ins_pct));
      if (drain_every > 0 && n % drain_every == drain_every - 1)
        wait_drained();
      else if (idle_on && $urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 15));
    end
  endtask

  task automatic test_random_traffic();
    run_phase(5'd16, 400, 45, 1'b1, 0);
    // insert-heavy so the table fills; sender stops now and then until all results are in
    run_phase(5'd31, 250, 60, 1'b1, 100);
    run_phase(5'd1, 150, 40, 1'b1, 0);
    run_phase(5'd0, 30, 40, 1'b1, 0);
    run_phase(5'd5, 250, 45, 1'b1, 0);
    run_phase(ACT_W'($urandom_range(1, 16)), 250, 50, 1'b1, 0);
  endtask

  task automatic test_back_to_back();
    run_phase(5'd16, 350, 45, 1'b0, 0);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result err=%0d slot=%0d space=%0d", $realtime,
                   out_item.error_code, out_item.slot_used, out_item.has_space);
      end else begin
        want = pending_results.pop_front();
        if (out_item.error_code !== want.error_code || out_item.slot_used !== want.slot_used ||
            out_item.has_space !== want.has_space) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch err %0d/%0d slot %0d/%0d space %0d/%0d (exp/got)",
                     $realtime, want.error_code, out_item.error_code, want.slot_used,
                     out_item.slot_used, want.has_space, out_item.has_space);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("reservation_station_table verification failed");
    $finish;
  end

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    act_cfg = ACT_W'(ENTRY_COUNT);
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_sched[i] = 1'b0;
    end
    num_pool[0] = 32'h0000_0000;
    num_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) num_pool[i] = $urandom();
    tag_pool[0] = 8'h00;
    tag_pool[1] = 8'hFF;
    for (int i = 2; i < 6; i++) tag_pool[i] = TAG_WIDTH'($urandom_range(0, 255));
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_ops();
    test_window_limits();
    test_shrunk_window();
    test_random_traffic();
    test_back_to_back();

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("reservation_station_table verification clean");
    end else begin
      $display("reservation_station_table verification failed");
    end
    $finish;
  end

endmodule
